### rtl/ntp_pkg.sv
`timescale 1ns / 1ps
// ntp_pkg: shared types and constants of the note on/off pairing block
// used by ntp_front, ntp_back and note_on_off_pairing; depends on nothing

package ntp_pkg;

   localparam int TICK_W     = 31;
   localparam int CHAN_W     = 4;
   localparam int KEY_W      = 7;
   localparam int VEL_W      = 7;
   localparam int OUT_CHAN_W = 5;

   // event kind codes on req_type
   localparam logic REQ_NOTE_ON  = 1'b0;
   localparam logic REQ_NOTE_OFF = 1'b1;

   // result kind codes on rsp_result_kind
   localparam logic KIND_NOTE = 1'b0;
   localparam logic KIND_DROP = 1'b1;

   // classified event handed from the front to the back
   typedef struct packed {
      logic              is_off;
      logic [CHAN_W-1:0] chan;
      logic [KEY_W-1:0]  key;
      logic [TICK_W-1:0] tick;
   } ntp_item_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_STORE
   } back_state_type;

endpackage

### rtl/note_on_off_pairing.sv
`timescale 1ns / 1ps
// note_on_off_pairing: pairs note-on events with later note-off events
// instantiates ntp_front and ntp_back; depends on ntp_pkg
//
// req_* carries one event per transfer (valid/stall). A note-on queues its tick for
// its channel and key; a note-off, or a note-on of velocity zero, takes the oldest
// queued tick and returns start, length, key and channel on rsp_* (valid/stall).
// A note-on meeting a full queue returns a drop result instead. Events with no
// pending note, ending before their start, or outside the configured channels
// and keys return nothing. csr_wr_en/csr_wr_data set separate_channels; when it
// is 0 the channel comes back as -1. Write it only while the block is idle.
// A drop result is taken from the queue state memory read, and a completed note
// from the tick memory read that follows it. The sequencer takes one event at a
// time: IDLE and EXEC for a note-on, IDLE, EXEC and STORE for a paired note-off.
// A two-entry queue decouples input from the sequencer, and the result register
// lets the next event proceed while a result waits under stall; the sequencer
// holds only when it must place a new result into a full register.
// After reset a clearing pass zeroes the per-key state, one key per cycle,
// over all CHANNEL_COUNT * KEY_COUNT queues (2048 by default); req_stall stays high.

module note_on_off_pairing #(
   parameter int CHANNEL_COUNT = 16,
   parameter int KEY_COUNT     = 128,
   parameter int QUEUE_DEPTH   = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic                                  csr_wr_data,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_type,
   input  logic [ntp_pkg::CHAN_W-1:0]            req_chan,
   input  logic [ntp_pkg::KEY_W-1:0]             req_note_key,
   input  logic [ntp_pkg::VEL_W-1:0]             req_velocity,
   input  logic [ntp_pkg::TICK_W-1:0]            req_event_tick,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_result_kind,
   output logic [ntp_pkg::TICK_W-1:0]            rsp_start_tick,
   output logic [ntp_pkg::TICK_W-1:0]            rsp_note_length,
   output logic [ntp_pkg::KEY_W-1:0]             rsp_out_key,
   output logic signed [ntp_pkg::OUT_CHAN_W-1:0] rsp_out_chan
);
   import ntp_pkg::*;

   logic         separate_channels_ff, separate_channels_in;
   logic         item_valid;
   ntp_item_type item;
   logic         item_take;
   logic         clearing;

   assign separate_channels_in = csr_wr_en ? csr_wr_data : separate_channels_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         separate_channels_ff <= 1'b0;
      end else begin
         separate_channels_ff <= separate_channels_in;
      end
   end

   ntp_front #(
      .CHANNEL_COUNT (CHANNEL_COUNT),
      .KEY_COUNT     (KEY_COUNT)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_chan       (req_chan),
      .req_note_key   (req_note_key),
      .req_velocity   (req_velocity),
      .req_event_tick (req_event_tick),
      .clearing       (clearing),
      .item_valid     (item_valid),
      .item           (item),
      .item_take      (item_take)
   );

   ntp_back #(
      .CHANNEL_COUNT (CHANNEL_COUNT),
      .KEY_COUNT     (KEY_COUNT),
      .QUEUE_DEPTH   (QUEUE_DEPTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .separate_channels (separate_channels_ff),
      .item_valid        (item_valid),
      .item              (item),
      .item_take         (item_take),
      .clearing          (clearing),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_start_tick    (rsp_start_tick),
      .rsp_note_length   (rsp_note_length),
      .rsp_out_key       (rsp_out_key),
      .rsp_out_chan      (rsp_out_chan)
   );

`ifndef SYNTHESIS
   // no event transfer while the state memory is being cleared
   a_clear_blocks_req: assert property (@(posedge clock) disable iff (reset)
      clearing |-> req_stall)
      else $error("event transfer during clearing pass");

   // the sequencer works on one event at a time
   a_take_spacing: assert property (@(posedge clock) disable iff (reset)
      item_take |=> !item_take)
      else $error("sequencer took events in consecutive cycles");

   a_take_needs_item: assert property (@(posedge clock) disable iff (reset)
      item_take |-> item_valid && !clearing)
      else $error("sequencer took from an empty queue");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> clearing && !rsp_valid)
      else $error("clearing pass did not start after reset");
`endif

endmodule

### rtl/ntp_front.sv
`timescale 1ns / 1ps
// ntp_front: accepts events, classifies them and queues them for the back
// depends on ntp_pkg

module ntp_front #(
   parameter int CHANNEL_COUNT = 16,
   parameter int KEY_COUNT     = 128
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_type,
   input  logic [ntp_pkg::CHAN_W-1:0]   req_chan,
   input  logic [ntp_pkg::KEY_W-1:0]    req_note_key,
   input  logic [ntp_pkg::VEL_W-1:0]    req_velocity,
   input  logic [ntp_pkg::TICK_W-1:0]   req_event_tick,
   input  logic                         clearing,
   output logic                         item_valid,
   output ntp_pkg::ntp_item_type        item,
   input  logic                         item_take
);
   import ntp_pkg::*;

   localparam logic [CHAN_W:0] CHAN_LIMIT = (CHAN_W + 1)'(CHANNEL_COUNT);
   localparam logic [KEY_W:0]  KEY_LIMIT  = (KEY_W + 1)'(KEY_COUNT);

   ntp_item_type fifo_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         in_range;
   logic         push;
   ntp_item_type new_item;

   assign req_stall = (count_ff == 2'd2) || clearing;

   // events outside the configured channels or keys are taken and dropped
   assign in_range = ({1'b0, req_chan} < CHAN_LIMIT) && ({1'b0, req_note_key} < KEY_LIMIT);
   assign push     = req_valid && !req_stall && in_range;

   always_comb begin
      new_item.is_off = (req_type == REQ_NOTE_OFF) || (req_velocity == '0);
      new_item.chan   = req_chan;
      new_item.key    = req_note_key;
      new_item.tick   = req_event_tick;
   end

   assign item_valid = (count_ff != 2'd0);
   assign item       = fifo_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = item_take ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(item_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

### rtl/ntp_back.sv
`timescale 1ns / 1ps
// ntp_back: per-key queue state in memories, pairing sequencer and result register
// depends on ntp_pkg

module ntp_back #(
   parameter int CHANNEL_COUNT = 16,
   parameter int KEY_COUNT     = 128,
   parameter int QUEUE_DEPTH   = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                separate_channels,
   input  logic                                item_valid,
   input  ntp_pkg::ntp_item_type               item,
   output logic                                item_take,
   output logic                                clearing,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_result_kind,
   output logic [ntp_pkg::TICK_W-1:0]          rsp_start_tick,
   output logic [ntp_pkg::TICK_W-1:0]          rsp_note_length,
   output logic [ntp_pkg::KEY_W-1:0]           rsp_out_key,
   output logic signed [ntp_pkg::OUT_CHAN_W-1:0] rsp_out_chan
);
   import ntp_pkg::*;

   localparam int QUEUE_TOTAL = CHANNEL_COUNT * KEY_COUNT;
   localparam int STORE_TOTAL = QUEUE_TOTAL * QUEUE_DEPTH;
   localparam int QW = (QUEUE_TOTAL > 1) ? $clog2(QUEUE_TOTAL) : 1;
   localparam int SW = (STORE_TOTAL > 1) ? $clog2(STORE_TOTAL) : 1;
   localparam int HW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int MW = CW + HW;

   back_state_type    state_ff, state_in;
   logic [QW-1:0]     clr_ff, clr_in;
   ntp_item_type      cur_ff;
   logic [QW-1:0]     q_ff;
   logic [QW-1:0]     in_q;

   // count and head of each queue, and the pending start ticks
   logic [MW-1:0]     meta_mem [QUEUE_TOTAL];
   logic [MW-1:0]     meta_rd_ff;
   logic [TICK_W-1:0] store_mem [STORE_TOTAL];
   logic [TICK_W-1:0] store_rd_ff;

   logic              meta_rd_en;
   logic              meta_wr_en;
   logic [QW-1:0]     meta_wr_addr;
   logic [MW-1:0]     meta_wr_data;
   logic              store_rd_en;
   logic              store_wr_en;
   logic [SW-1:0]     store_base;
   logic [SW-1:0]     store_rd_addr;
   logic [SW-1:0]     store_wr_addr;

   logic [CW-1:0]     cur_cnt;
   logic [HW-1:0]     cur_head;
   logic [HW-1:0]     head_next;
   logic [HW:0]       slot_sum;
   logic [HW-1:0]     tail_slot;
   logic              queue_empty;
   logic              queue_full;
   logic              clr_last;
   logic              early;
   logic              out_free;

   logic              out_load;
   logic              out_kind;
   logic [TICK_W-1:0] out_start;
   logic [TICK_W-1:0] out_length;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          kind_ff;
   logic [TICK_W-1:0]             start_ff;
   logic [TICK_W-1:0]             length_ff;
   logic [KEY_W-1:0]              key_ff;
   logic signed [OUT_CHAN_W-1:0]  chan_ff;

   assign in_q = QW'(QW'(item.chan) * QW'(KEY_COUNT) + QW'(item.key));

   assign cur_cnt     = meta_rd_ff[MW-1:HW];
   assign cur_head    = meta_rd_ff[HW-1:0];
   assign queue_empty = (cur_cnt == '0);
   assign queue_full  = (cur_cnt >= CW'(QUEUE_DEPTH));
   assign head_next   = (cur_head == HW'(QUEUE_DEPTH - 1)) ? '0 : HW'(cur_head + 1'b1);

   // head + count wraps at most once since count is below the depth here
   assign slot_sum  = (HW + 1)'(cur_head) + (HW + 1)'(cur_cnt);
   assign tail_slot = (slot_sum >= (HW + 1)'(QUEUE_DEPTH)) ?
                      HW'(slot_sum - (HW + 1)'(QUEUE_DEPTH)) : HW'(slot_sum);

   assign store_base    = SW'(SW'(q_ff) * SW'(QUEUE_DEPTH));
   assign store_rd_addr = SW'(store_base + SW'(cur_head));
   assign store_wr_addr = SW'(store_base + SW'(tail_slot));

   assign clr_last = (clr_ff == QW'(QUEUE_TOTAL - 1));
   assign early    = (cur_ff.tick < store_rd_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (item_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (cur_ff.is_off) begin
               state_in = queue_empty ? ST_IDLE : ST_STORE;
            end else if (!queue_full || out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_STORE: begin
            if (early || out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      item_take    = 1'b0;
      clearing     = 1'b0;
      clr_in       = clr_ff;
      meta_rd_en   = 1'b0;
      meta_wr_en   = 1'b0;
      meta_wr_addr = q_ff;
      meta_wr_data = '0;
      store_rd_en  = 1'b0;
      store_wr_en  = 1'b0;
      out_load     = 1'b0;
      out_kind     = KIND_NOTE;
      out_start    = store_rd_ff;
      out_length   = TICK_W'(cur_ff.tick - store_rd_ff);
      unique case (state_ff)
         ST_CLEAR: begin
            clearing     = 1'b1;
            meta_wr_en   = 1'b1;
            meta_wr_addr = clr_ff;
            clr_in       = QW'(clr_ff + 1'b1);
         end
         ST_IDLE: begin
            item_take  = item_valid;
            meta_rd_en = item_valid;
         end
         ST_EXEC: begin
            if (cur_ff.is_off) begin
               if (!queue_empty) begin
                  meta_wr_en   = 1'b1;
                  meta_wr_data = {CW'(cur_cnt - 1'b1), head_next};
                  store_rd_en  = 1'b1;
               end
            end else if (queue_full) begin
               out_load   = out_free;
               out_kind   = KIND_DROP;
               out_start  = cur_ff.tick;
               out_length = '0;
            end else begin
               meta_wr_en   = 1'b1;
               meta_wr_data = {CW'(cur_cnt + 1'b1), cur_head};
               store_wr_en  = 1'b1;
            end
         end
         ST_STORE: begin
            // a note-off before its start is consumed without a result
            out_load = !early && out_free;
         end
         default: begin
            clearing = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_take) begin
         cur_ff <= item;
         q_ff   <= in_q;
      end
   end

   always_ff @(posedge clock) begin
      if (meta_wr_en) begin
         meta_mem[meta_wr_addr] <= meta_wr_data;
      end
      if (meta_rd_en) begin
         meta_rd_ff <= meta_mem[in_q];
      end
   end

   always_ff @(posedge clock) begin
      if (store_wr_en) begin
         store_mem[store_wr_addr] <= cur_ff.tick;
      end
      if (store_rd_en) begin
         store_rd_ff <= store_mem[store_rd_addr];
      end
   end

   // result register
   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         kind_ff   <= out_kind;
         start_ff  <= out_start;
         length_ff <= out_length;
         key_ff    <= cur_ff.key;
         chan_ff   <= separate_channels ? $signed({1'b0, cur_ff.chan}) : '1;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_start_tick  = start_ff;
   assign rsp_note_length = length_ff;
   assign rsp_out_key     = key_ff;
   assign rsp_out_chan    = chan_ff;

endmodule

### bench/tb_note_on_off_pairing.sv
`timescale 1ns / 1ps
// tb_note_on_off_pairing: self-checking bench for note_on_off_pairing, with a
// per-key pending-note predictor and random idling on both channels
// depends on ntp_pkg and the note_on_off_pairing rtl

module tb_note_on_off_pairing;
   import ntp_pkg::*;

   localparam int CHANNELS     = 16;
   localparam int KEYS         = 128;
   localparam int DEPTH        = 4;
   localparam int QUEUE_TOTAL  = CHANNELS * KEYS;
   localparam int SETTLE_WAIT  = 16;
   localparam int HOLD_CYCLES  = 300;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASES       = 6;
   localparam int PHASE_EVENTS = 225;

   typedef struct packed {
      logic                         kind;
      logic [TICK_W-1:0]            start_tick;
      logic [TICK_W-1:0]            note_length;
      logic [KEY_W-1:0]             out_key;
      logic signed [OUT_CHAN_W-1:0] out_chan;
   } note_result_type;

   logic                                  clock          = 1'b0;
   logic                                  reset          = 1'b1;
   logic                                  csr_wr_en      = 1'b0;
   logic                                  csr_wr_data    = 1'b0;
   logic                                  req_valid      = 1'b0;
   logic                                  req_stall;
   logic                                  req_type       = REQ_NOTE_ON;
   logic [CHAN_W-1:0]                     req_chan       = '0;
   logic [KEY_W-1:0]                      req_note_key   = '0;
   logic [VEL_W-1:0]                      req_velocity   = '0;
   logic [TICK_W-1:0]                     req_event_tick = '0;
   logic                                  rsp_valid;
   logic                                  rsp_stall;
   logic                                  rsp_result_kind;
   logic [TICK_W-1:0]                     rsp_start_tick;
   logic [TICK_W-1:0]                     rsp_note_length;
   logic [KEY_W-1:0]                      rsp_out_key;
   logic signed [OUT_CHAN_W-1:0]          rsp_out_chan;

   // receiver stall is the per-result draw or-ed with the long hold-off
   logic rsp_stall_draw = 1'b0;
   logic hold_stall     = 1'b0;
   assign rsp_stall = rsp_stall_draw | hold_stall;

   // predictor state: pending start ticks per channel and key
   logic [TICK_W-1:0] held_tick [QUEUE_TOTAL][DEPTH];
   int                held_count [QUEUE_TOTAL];
   int                held_head [QUEUE_TOTAL];
   logic              tag_channels = 1'b0;

   note_result_type   awaited [$];

   bit send_idle = 1'b1;
   bit recv_idle = 1'b1;
   int errors    = 0;
   int events_sent = 0;
   int notes_seen  = 0;
   int drops_seen  = 0;
   int cycles      = 0;

   note_on_off_pairing dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_chan        (req_chan),
      .req_note_key    (req_note_key),
      .req_velocity    (req_velocity),
      .req_event_tick  (req_event_tick),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_start_tick  (rsp_start_tick),
      .rsp_note_length (rsp_note_length),
      .rsp_out_key     (rsp_out_key),
      .rsp_out_chan    (rsp_out_chan)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still awaited", cycles,
                  awaited.size());
         $display("simulation failed");
         $finish;
      end
   end

   function automatic int draw_wait(input bit enabled);
      return enabled ? $urandom_range(0, 6) : 0;
   endfunction

   // pairs one event against the pending notes of its channel and key
   function automatic bit pair_event(input logic kind, input logic [CHAN_W-1:0] ch,
                                     input logic [KEY_W-1:0] key,
                                     input logic [VEL_W-1:0] vel,
                                     input logic [TICK_W-1:0] tick,
                                     output note_result_type res);
      int q;
      logic [TICK_W-1:0] start;
      res = '0;
      if (ch >= CHANNELS || key >= KEYS)
         return 1'b0;
      q = int'(ch) * KEYS + int'(key);
      res.out_key  = key;
      res.out_chan = tag_channels ? $signed({1'b0, ch}) : -5'sd1;
      if (kind == REQ_NOTE_OFF || vel == '0) begin
         if (held_count[q] == 0)
            return 1'b0;
         start = held_tick[q][held_head[q]];
         held_head[q] = (held_head[q] + 1) % DEPTH;
         held_count[q]--;
         // a release earlier than its start still consumes the note
         if (tick < start)
            return 1'b0;
         res.kind        = KIND_NOTE;
         res.start_tick  = start;
         res.note_length = tick - start;
         return 1'b1;
      end
      if (held_count[q] >= DEPTH) begin
         res.kind        = KIND_DROP;
         res.start_tick  = tick;
         res.note_length = '0;
         return 1'b1;
      end
      held_tick[q][(held_head[q] + held_count[q]) % DEPTH] = tick;
      held_count[q]++;
      return 1'b0;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (errors < 40)
         $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got,
                  want);
      errors++;
   endtask

   task automatic send_event(input logic kind, input logic [CHAN_W-1:0] ch,
                             input logic [KEY_W-1:0] key, input logic [VEL_W-1:0] vel,
                             input logic [TICK_W-1:0] tick);
      int gap;
      note_result_type res;
      gap = draw_wait(send_idle);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_chan       <= ch;
      req_note_key   <= key;
      req_velocity   <= vel;
      req_event_tick <= tick;
      do @(posedge clock); while (req_stall);
      events_sent++;
      if (pair_event(kind, ch, key, vel, tick, res))
         awaited = {awaited, res};
   endtask

   // stop offering, wait for every awaited result, then let in-flight events finish
   task automatic settle();
      req_valid <= 1'b0;
      while (awaited.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic set_channel_tags(input logic on);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= on;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      tag_channels = on;
   endtask

   // receiver: a random stall before each transfer
   initial begin : receiver
      int wait_n;
      forever begin
         wait_n = draw_wait(recv_idle);
         if (wait_n > 0) begin
            rsp_stall_draw <= 1'b1;
            repeat (wait_n) @(posedge clock);
         end
         rsp_stall_draw <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   always @(posedge clock) begin : check_results
      note_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited.size() == 0) begin
            report_mismatch("unexpected result, start_tick", 32'(rsp_start_tick), '0);
         end else begin
            want = awaited[0];
            awaited.delete(0);
            if (want.kind == KIND_DROP)
               drops_seen++;
            else
               notes_seen++;
            if (rsp_result_kind !== want.kind)
               report_mismatch("result_kind", 32'(rsp_result_kind), 32'(want.kind));
            if (rsp_start_tick !== want.start_tick)
               report_mismatch("start_tick", 32'(rsp_start_tick), 32'(want.start_tick));
            if (rsp_note_length !== want.note_length)
               report_mismatch("note_length", 32'(rsp_note_length),
                               32'(want.note_length));
            if (rsp_out_key !== want.out_key)
               report_mismatch("out_key", 32'(rsp_out_key), 32'(want.out_key));
            if (rsp_out_chan !== want.out_chan)
               report_mismatch("out_chan", 32'(rsp_out_chan), 32'(want.out_chan));
         end
      end
   end

   // extremes, zero-velocity release, full queue, early release, empty release
   task automatic test_edge_cases();
      send_event(REQ_NOTE_OFF, 4'd15, 7'd127, 7'd127, 31'h7FFF_FFFF);
      send_event(REQ_NOTE_ON, 4'd0, 7'd0, 7'd127, 31'd0);
      send_event(REQ_NOTE_OFF, 4'd0, 7'd0, 7'd0, 31'h7FFF_FFFF);
      send_event(REQ_NOTE_ON, 4'd15, 7'd127, 7'd1, 31'd100);
      send_event(REQ_NOTE_ON, 4'd15, 7'd127, 7'd0, 31'd150);
      send_event(REQ_NOTE_ON, 4'd5, 7'd64, 7'd85, 31'd10);
      send_event(REQ_NOTE_ON, 4'd5, 7'd64, 7'd42, 31'd20);
      send_event(REQ_NOTE_ON, 4'd5, 7'd64, 7'd127, 31'd30);
      send_event(REQ_NOTE_ON, 4'd5, 7'd64, 7'd1, 31'd40);
      send_event(REQ_NOTE_ON, 4'd5, 7'd64, 7'd99, 31'h5555_5555);
      send_event(REQ_NOTE_OFF, 4'd5, 7'd64, 7'd64, 31'd25);
      send_event(REQ_NOTE_OFF, 4'd5, 7'd64, 7'd64, 31'd5);
      send_event(REQ_NOTE_ON, 4'd5, 7'd64, 7'd0, 31'd30);
      send_event(REQ_NOTE_OFF, 4'd5, 7'd64, 7'd127, 31'h7FFF_FFFF);
      send_event(REQ_NOTE_OFF, 4'd5, 7'd64, 7'd127, 31'h7FFF_FFFF);
      send_event(REQ_NOTE_ON, 4'd10, 7'h55, 7'h2A, 31'h2AAA_AAAA);
      send_event(REQ_NOTE_OFF, 4'd10, 7'h55, 7'h55, 31'h5555_5555);
      settle();
   endtask

   task automatic test_channel_tagging();
      set_channel_tags(1'b1);
      send_event(REQ_NOTE_ON, 4'd15, 7'd127, 7'd127, 31'h7FFF_FFFF);
      send_event(REQ_NOTE_ON, 4'd15, 7'd127, 7'd0, 31'h7FFF_FFFF);
      send_event(REQ_NOTE_ON, 4'd0, 7'd0, 7'd64, 31'd5);
      send_event(REQ_NOTE_OFF, 4'd0, 7'd0, 7'd0, 31'd9);
      settle();
   endtask

   // long receiver hold-off while the sender keeps offering
   task automatic test_backpressure();
      int k;
      send_idle = 1'b0;
      fork
         begin
            hold_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_stall <= 1'b0;
         end
      join_none
      for (k = 0; k < 16; k++) begin
         send_event(REQ_NOTE_ON, 4'(k), 7'(k * 8), 7'd100, 31'(1000 + k));
         send_event(REQ_NOTE_OFF, 4'(k), 7'(k * 8), 7'd100, 31'(2000 + k * 3));
      end
      // sender pauses here until every result has drained
      settle();
      send_idle = 1'b1;
   endtask

   // well-formed on/off traffic on a few hot keys, with some raw noise
   task automatic test_random_traffic();
      logic [CHAN_W-1:0] pool_chan [4];
      logic [KEY_W-1:0]  pool_key [4];
      logic [TICK_W-1:0] now;
      int p, i, j, pick, roll;
      for (p = 0; p < PHASES; p++) begin
         if (p > 0)
            set_channel_tags(logic'(p % 2));
         for (j = 0; j < 4; j++) begin
            pool_chan[j] = CHAN_W'($urandom());
            pool_key[j]  = KEY_W'($urandom());
         end
         if (p == PHASES - 1) begin
            pool_chan[0] = 4'd15;
            pool_key[0]  = 7'd127;
         end
         now = TICK_W'($urandom());
         for (i = 0; i < PHASE_EVENTS; i++) begin
            if (i % 50 == 0) begin
               send_idle = ($urandom_range(0, 2) != 0);
               recv_idle = ($urandom_range(0, 2) != 0);
            end
            roll = $urandom_range(0, 99);
            pick = $urandom_range(0, 3);
            now  = now + TICK_W'($urandom_range(0, 300));
            if (roll < 46)
               send_event(REQ_NOTE_ON, pool_chan[pick], pool_key[pick],
                          VEL_W'($urandom_range(1, 127)), now);
            else if (roll < 70)
               send_event(REQ_NOTE_OFF, pool_chan[pick], pool_key[pick],
                          VEL_W'($urandom()), now);
            else if (roll < 88)
               send_event(REQ_NOTE_ON, pool_chan[pick], pool_key[pick], '0, now);
            else
               send_event(logic'($urandom()), CHAN_W'($urandom()), KEY_W'($urandom()),
                          VEL_W'($urandom()), TICK_W'($urandom()));
         end
      end
      send_idle = 1'b1;
      recv_idle = 1'b1;
      settle();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_edge_cases();
      test_channel_tagging();
      set_channel_tags(1'b0);
      test_backpressure();
      test_random_traffic();
      settle();
      while (awaited.size() != 0) begin
         report_mismatch("missing result, start_tick", '0, 32'(awaited[0].start_tick));
         awaited.delete(0);
      end
      $display("covered %0d events with both channel settings and a long result hold-off",
               events_sent);
      $display("checked %0d completed notes and %0d full-queue drops, %0d mismatches",
               notes_seen, drops_seen, errors);
      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

### files.f
rtl/ntp_pkg.sv
rtl/ntp_front.sv
rtl/ntp_back.sv
rtl/note_on_off_pairing.sv
bench/tb_note_on_off_pairing.sv
